// ===== src/tsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TSP search package
// Shared types, constants and command/status structs for the search block.
// ---------------------------------------------------------------------------
package tsp_pkg;

    localparam int MaxCitiesDef = 16;
    localparam int CostBitsDef  = 16;
    localparam int LimitBits    = 20;
    localparam logic [LimitBits-1:0] LimitReset = 20'd1000000;

    localparam logic [0:0] CfgNumCities = 1'b0;
    localparam logic [0:0] CfgCostLimit = 1'b1;

    localparam logic ActLoad = 1'b0;
    localparam logic ActRun  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  from_city;
        logic [3:0]  to_city;
        logic [15:0] edge_cost;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  position;
        logic [3:0]  city;
        logic [19:0] total_cost;
        logic        found;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_BACK_READ,
        ST_BACK,
        ST_EMIT,
        ST_WAIT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // write one matrix entry
        logic init;       // start of a run
        logic rd_back;    // read edge of the top stack level
        logic eval;       // test candidate, push or advance
        logic pop;        // remove the top level
        logic emit_first; // set output index to zero
        logic emit_next;  // advance output index
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic leaf;       // depth equals the city count
        logic cand_end;   // candidate counter reached the city count
        logic pushed;     // last evaluation pushed a city
        logic at_bottom;  // depth is one
        logic emit_done;  // last result presented
    } t_status;

endpackage
`default_nettype wire

// ===== src/tsp_branch_and_bound_search.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TSP branch-and-bound search
// Depth-first search over a stored cost matrix with explicit stack.
// ---------------------------------------------------------------------------
//  channel | signals                      | direction
//  in      | i_in_valid/o_in_ready/i_in   | request: load edge or run
//  out     | o_out_valid/i_out_ready/o_out| result city of best tour
//  cfg     | i_cfg_valid/o_cfg_ready      | register write
// A load writes one matrix entry. Each search step of a run reads the edge,
// evaluates and settles, and each backtrack reads the edge back and pops, paced by
// the single matrix read port; then one result per cycle while taken.
// Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module tsp_branch_and_bound_search #(
    parameter int MAX_CITIES = tsp_pkg::MaxCitiesDef,
    parameter int COST_BITS  = tsp_pkg::CostBitsDef
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire tsp_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output tsp_pkg::t_out_item     o_out,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [0:0]              i_cfg_index,
    input  wire [19:0]             i_cfg_data
);
    import tsp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic [4:0]  r_num_cities;
    logic [19:0] r_cost_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cities <= 5'd1;
            r_cost_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgNumCities: r_num_cities <= i_cfg_data[4:0];
                CfgCostLimit: r_cost_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tsp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_in.action),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    tsp_datapath #(
        .MAX_CITIES(MAX_CITIES),
        .COST_BITS (COST_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_item      (i_in),
        .i_num_cities(r_num_cities),
        .i_cost_limit(r_cost_limit),
        .o_result    (o_out)
    );

endmodule
`default_nettype wire

// ===== src/tsp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TSP datapath
// Cost matrix memory, path stack, candidate counters, costs and best tour.
// ---------------------------------------------------------------------------
module tsp_datapath #(
    parameter int MAX_CITIES = tsp_pkg::MaxCitiesDef,
    parameter int COST_BITS  = tsp_pkg::CostBitsDef
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire tsp_pkg::t_cmd    i_cmd,
    output tsp_pkg::t_status      o_status,
    input  wire tsp_pkg::t_in_item i_item,
    input  wire [4:0]             i_num_cities,
    input  wire [19:0]            i_cost_limit,
    output tsp_pkg::t_out_item    o_result
);
    import tsp_pkg::*;

    localparam int CW = $clog2(MAX_CITIES) > 0 ? $clog2(MAX_CITIES) : 1;
    localparam int DW = $clog2(MAX_CITIES + 1);
    localparam int SW = LimitBits + 1;
    localparam int AW = $clog2(MAX_CITIES * MAX_CITIES) > 0 ?
                        $clog2(MAX_CITIES * MAX_CITIES) : 1;

    logic [COST_BITS-1:0] r_mem [MAX_CITIES*MAX_CITIES];
    logic [COST_BITS-1:0] r_rd;
    logic [CW-1:0]        r_path [MAX_CITIES+1];
    logic [DW-1:0]        r_cand [MAX_CITIES+1];
    logic [CW-1:0]        r_best [MAX_CITIES+1];
    logic [MAX_CITIES-1:0] r_vis;
    logic [LimitBits-1:0] r_cur;
    logic [LimitBits-1:0] r_best_cost;
    logic                 r_found;
    logic [DW-1:0]        r_depth;
    logic [DW-1:0]        r_n;
    logic [DW-1:0]        r_idx;
    logic                 r_pushed;

    logic [DW-1:0] w_n;
    logic [4:0]    w_ncl;
    logic [CW-1:0] w_prev;
    logic [DW-1:0] w_c;
    logic [SW-1:0] w_sum;
    logic          w_free;
    logic          w_in_range;
    logic [2*CW-1:0] w_addr;

    always_comb begin
        w_ncl = i_num_cities;
        if (w_ncl == 5'd0) w_ncl = 5'd1;
        if (32'(w_ncl) > MAX_CITIES) w_n = DW'(MAX_CITIES);
        else w_n = DW'(w_ncl);
    end

    assign w_prev = r_path[r_depth - DW'(1)];
    assign w_c    = r_cand[r_depth];
    assign w_sum  = SW'(r_cur) + SW'(r_rd);
    assign w_free = !r_vis[w_c[CW-1:0]];
    assign w_in_range = (32'(i_item.from_city) < MAX_CITIES) &&
                        (32'(i_item.to_city) < MAX_CITIES);

    // On a backtrack the edge read is the one that led into the top level.
    always_comb begin
        if (i_cmd.rd_back) begin
            w_addr = {r_path[r_depth - DW'(2)], r_path[r_depth - DW'(1)]};
        end else if (r_depth == r_n) begin
            w_addr = {w_prev, CW'(0)};
        end else begin
            w_addr = {w_prev, w_c[CW-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_in_range) begin
            r_mem[AW'(int'(i_item.from_city) * MAX_CITIES + int'(i_item.to_city))] <=
                COST_BITS'(i_item.edge_cost);
        end
        r_rd <= r_mem[AW'(int'(w_addr[2*CW-1:CW]) * MAX_CITIES + int'(w_addr[CW-1:0]))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= DW'(1);
            r_vis    <= MAX_CITIES'(1);
            r_cur    <= '0;
            r_found  <= 1'b0;
            r_pushed <= 1'b0;
            r_n      <= DW'(1);
            r_idx    <= '0;
            r_best_cost <= LimitReset;
            r_path[0] <= '0;
        end else begin
            if (i_cmd.init) begin
                r_n         <= w_n;
                r_depth     <= DW'(1);
                r_vis       <= MAX_CITIES'(1);
                r_cur       <= '0;
                r_found     <= 1'b0;
                r_best_cost <= i_cost_limit;
                r_cand[1]   <= DW'(1);
                r_path[0]   <= '0;
                r_pushed    <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_pushed <= 1'b0;
                if (r_depth == r_n) begin
                    if (w_sum < SW'(r_best_cost)) begin
                        for (int i = 0; i <= MAX_CITIES; i++) begin
                            if (DW'(i) < r_n) r_best[i] <= r_path[i];
                            else if (DW'(i) == r_n) r_best[i] <= '0;
                        end
                        r_best_cost <= w_sum[LimitBits-1:0];
                        r_found     <= 1'b1;
                    end
                end else if (w_free && w_sum < SW'(r_best_cost)) begin
                    r_cand[r_depth]         <= w_c + DW'(1);
                    r_path[r_depth]         <= w_c[CW-1:0];
                    r_vis[w_c[CW-1:0]]      <= 1'b1;
                    r_cur                   <= w_sum[LimitBits-1:0];
                    r_depth                 <= r_depth + DW'(1);
                    r_cand[r_depth + DW'(1)] <= DW'(1);
                    r_pushed                <= 1'b1;
                end else begin
                    r_cand[r_depth] <= w_c + DW'(1);
                end
            end
            if (i_cmd.pop) begin
                r_cur   <= r_cur - LimitBits'(r_rd);
                r_vis[r_path[r_depth]] <= 1'b0;
            end
            if (i_cmd.rd_back) r_depth <= r_depth - DW'(1);
            if (i_cmd.emit_first) r_idx <= '0;
            if (i_cmd.emit_next)  r_idx <= r_idx + DW'(1);
        end
    end

    assign o_status.leaf      = (r_depth == r_n);
    assign o_status.cand_end  = (w_c >= r_n);
    assign o_status.pushed    = r_pushed;
    assign o_status.at_bottom = (r_depth <= DW'(1));
    assign o_status.emit_done = !r_found || (r_idx == r_n);

    always_comb begin
        o_result = '0;
        o_result.last = !r_found || (r_idx == r_n);
        if (r_found) begin
            o_result.position   = 5'(r_idx);
            o_result.city       = 4'(r_best[r_idx]);
            o_result.total_cost = r_best_cost;
            o_result.found      = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth >= DW'(1) && r_depth <= r_n)
        else $error("search depth out of range");
    a_home_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vis[0])
        else $error("home city lost from visited mask");
    a_cost_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_best_cost)
        else $error("partial tour cost above best cost");
`endif

endmodule
`default_nettype wire

// ===== src/tsp_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// TSP controller
// Sequences loads, the depth-first search and the delivery of results.
// ---------------------------------------------------------------------------
module tsp_controller (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_action,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tsp_pkg::t_cmd       o_cmd,
    input  wire tsp_pkg::t_status i_status
);
    import tsp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ActRun) begin
                        o_cmd.init = 1'b1;
                        n_state = ST_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_START: n_state = ST_READ;
            ST_READ: begin
                // Edge cost is registered from the memory this cycle.
                if (!i_status.leaf && i_status.cand_end) begin
                    n_state = ST_BACK_READ;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.pushed) n_state = ST_READ;
                else if (i_status.leaf) n_state = ST_BACK_READ;
                else n_state = ST_READ;
            end
            ST_BACK_READ: begin
                if (i_status.at_bottom) begin
                    o_cmd.emit_first = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.rd_back = 1'b1;
                    n_state = ST_BACK;
                end
            end
            ST_BACK: begin
                o_cmd.pop = 1'b1;
                n_state = ST_READ;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.emit_done) n_state = ST_IDLE;
                    else o_cmd.emit_next = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken while results pending");
    a_pop_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |-> $past(o_cmd.rd_back))
        else $error("pop without edge read");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.init, o_cmd.eval, o_cmd.pop, o_cmd.rd_back}))
        else $error("conflicting commands");
`endif

endmodule
`default_nettype wire
